>>> rtl/core/chss_pkg.sv
// ----------------------------------------------------------------------------
// chss_pkg
// Shared types and constants for the clock hand stepper sequencer.
// ----------------------------------------------------------------------------
package chss_pkg;

  localparam int STEP_W    = 19;   // step counter width
  localparam int ROT_W     = 29;   // |degrees| * steps_per_turn
  localparam int HAND_W    = 17;   // |move| * steps_per_minute
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [ROT_W-1:0]  DEG_PER_TURN = ROT_W'(360);

  localparam logic [15:0] RST_STEP_INTERVAL = 16'd2;
  localparam logic [11:0] RST_LIFT_STEPS    = 12'd114;
  localparam logic [7:0]  RST_STEPS_PER_MIN = 8'd52;
  localparam logic [12:0] RST_STEPS_PER_TURN = 13'd2048;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LIFT   = 3'd1,
    PH_TURN   = 3'd2,
    PH_LOWER  = 3'd3,
    PH_ROTATE = 3'd4
  } chss_phase_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_NOP    = 2'd3
  } chss_op_t;

  typedef enum logic [1:0] {
    CFG_STEP_INTERVAL = 2'd0,
    CFG_LIFT_STEPS    = 2'd1,
    CFG_STEPS_PER_MIN = 2'd2,
    CFG_STEPS_PER_TURN = 2'd3
  } chss_cfg_idx_t;

  typedef struct packed {
    logic [15:0] step_interval_ticks;
    logic [11:0] lift_steps;
    logic [7:0]  steps_per_minute;
    logic [12:0] steps_per_turn;
  } chss_cfg_t;

  typedef struct packed {
    logic [3:0]        first_coils;
    logic [3:0]        second_coils;
    logic              busy;
    chss_phase_t       phase;
    logic              taken;
    logic signed [7:0] settled_target;
  } chss_res_t;

endpackage

>>> rtl/core/clock_hand_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// clock_hand_stepper_sequencer
// Two wave-drive steppers: hand sequence (lift, turn, lower) and free rotate.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | opcode, target_minutes, rotate_degrees
//   out_    | output    | out_valid/out_stall| coils, busy, phase, taken, settled
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle while in_stall is low; its registered result shows next cycle.
// in_stall is high only while a result waits in the output register under
// out_stall. Rotate step counts use a 16x13 multiply in the item cycle and a
// running sum in place of a divide by 360. Synchronous reset idles the
// sequencer, clears the core's coil drive and loads the register defaults.
// ----------------------------------------------------------------------------
module clock_hand_stepper_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic signed [7:0] in_target_minutes,
  input  logic signed [15:0] in_rotate_degrees,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_first_coils,
  output logic [3:0]        out_second_coils,
  output logic              out_busy_res,
  output logic [2:0]        out_phase_now,
  output logic              out_command_taken,
  output logic signed [7:0] out_settled_target,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [chss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  chss_pkg::chss_cfg_t cfg_r;
  chss_pkg::chss_res_t res_nxt;
  chss_pkg::chss_res_t res_r;
  logic                out_valid_r;
  logic                accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_interval_ticks <= chss_pkg::RST_STEP_INTERVAL;
      cfg_r.lift_steps          <= chss_pkg::RST_LIFT_STEPS;
      cfg_r.steps_per_minute    <= chss_pkg::RST_STEPS_PER_MIN;
      cfg_r.steps_per_turn      <= chss_pkg::RST_STEPS_PER_TURN;
    end else if (cfg_we) begin
      case (chss_pkg::chss_cfg_idx_t'(cfg_index))
        chss_pkg::CFG_STEP_INTERVAL:  cfg_r.step_interval_ticks <= cfg_wdata;
        chss_pkg::CFG_LIFT_STEPS:     cfg_r.lift_steps          <= cfg_wdata[11:0];
        chss_pkg::CFG_STEPS_PER_MIN:  cfg_r.steps_per_minute    <= cfg_wdata[7:0];
        chss_pkg::CFG_STEPS_PER_TURN: cfg_r.steps_per_turn      <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  chss_seq_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_en        (accept),
    .opcode         (in_opcode),
    .target_minutes (in_target_minutes),
    .rotate_degrees (in_rotate_degrees),
    .cfg            (cfg_r),
    .res_nxt        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold payload while the result waits
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_coils    = res_r.first_coils;
  assign out_second_coils   = res_r.second_coils;
  assign out_busy_res       = res_r.busy;
  assign out_phase_now      = res_r.phase;
  assign out_command_taken  = res_r.taken;
  assign out_settled_target = res_r.settled_target;

  a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.busy |-> (res_r.first_coils == 4'd0) && (res_r.second_coils == 4'd0))
    else $error("coils driven while idle");

  a_taken_starts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.taken |->
      res_r.busy && ((res_r.phase == chss_pkg::PH_LIFT) || (res_r.phase == chss_pkg::PH_ROTATE)))
    else $error("taken command did not start a sequence");

  a_coils_wave: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(res_r.first_coils) && $onehot0(res_r.second_coils) &&
                    !((res_r.first_coils != 4'd0) && (res_r.second_coils != 4'd0)))
    else $error("coil drive not wave drive on one motor");

endmodule

>>> rtl/core/chss_seq_core.sv
// ----------------------------------------------------------------------------
// chss_seq_core
// Sequencer state and single-pass update for one item: tick pacing, lift,
// hand turn, lower and free rotate, with the post-update result view.
// ----------------------------------------------------------------------------
module chss_seq_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_en,
  input  logic [1:0]              opcode,
  input  logic signed [7:0]       target_minutes,
  input  logic signed [15:0]      rotate_degrees,
  input  chss_pkg::chss_cfg_t     cfg,
  output chss_pkg::chss_res_t     res_nxt
);

  chss_pkg::chss_phase_t           phase_r, phase_nxt;
  logic [chss_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [15:0]                     tick_r, tick_nxt;
  logic signed [8:0]               move_r, move_nxt;
  logic signed [7:0]               pending_r, pending_nxt;
  logic signed [7:0]               settled_r, settled_nxt;
  logic [chss_pkg::ROT_W-1:0]      rot_prod_r, rot_prod_nxt;
  logic [chss_pkg::ROT_W-1:0]      rot_acc_r, rot_acc_nxt;
  logic                            rot_fwd_r, rot_fwd_nxt;
  logic [1:0]                      first_ph_r, first_ph_nxt;
  logic [1:0]                      second_ph_r, second_ph_nxt;
  logic [3:0]                      first_drv_r, first_drv_nxt;
  logic [3:0]                      second_drv_r, second_drv_nxt;

  logic                            busy;
  logic                            taken;
  logic [16:0]                     tick_inc;
  logic [8:0]                      move_abs;
  logic [chss_pkg::HAND_W-1:0]     hand_total;
  logic [15:0]                     deg_bits;
  logic [15:0]                     deg_mag;
  logic [chss_pkg::ROT_W-1:0]      rot_prod;
  logic [8:0]                      move_new;
  logic [chss_pkg::STEP_W-1:0]     lift_ext;

  assign busy     = (phase_r != chss_pkg::PH_IDLE);
  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign move_abs = move_r[8] ? 9'(-move_r) : 9'(move_r);
  assign hand_total = chss_pkg::HAND_W'(move_abs) * chss_pkg::HAND_W'(cfg.steps_per_minute);
  assign deg_bits = rotate_degrees;
  assign deg_mag  = deg_bits[15] ? (~deg_bits + 16'd1) : deg_bits;
  assign rot_prod = chss_pkg::ROT_W'(deg_mag) * chss_pkg::ROT_W'(cfg.steps_per_turn);
  assign move_new = {target_minutes[7], target_minutes} - {settled_r[7], settled_r};
  assign lift_ext = chss_pkg::STEP_W'(cfg.lift_steps);

  always_comb begin
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    tick_nxt       = tick_r;
    move_nxt       = move_r;
    pending_nxt    = pending_r;
    settled_nxt    = settled_r;
    rot_prod_nxt   = rot_prod_r;
    rot_acc_nxt    = rot_acc_r;
    rot_fwd_nxt    = rot_fwd_r;
    first_ph_nxt   = first_ph_r;
    second_ph_nxt  = second_ph_r;
    first_drv_nxt  = first_drv_r;
    second_drv_nxt = second_drv_r;
    taken          = 1'b0;

    if (item_en) begin
      case (chss_pkg::chss_op_t'(opcode))
        chss_pkg::OP_TICK: begin
          if (busy) begin
            if (tick_inc >= {1'b0, cfg.step_interval_ticks}) begin
              tick_nxt = '0;
              case (phase_r)
                chss_pkg::PH_LIFT: begin
                  if (step_r < lift_ext) begin
                    second_ph_nxt  = second_ph_r + 2'd1;
                    second_drv_nxt = 4'd1 << second_ph_nxt;
                    step_nxt       = step_r + 1'b1;
                  end else begin
                    second_drv_nxt = '0;
                    phase_nxt      = chss_pkg::PH_TURN;
                    step_nxt       = '0;
                  end
                end
                chss_pkg::PH_TURN: begin
                  if (step_r < chss_pkg::STEP_W'(hand_total)) begin
                    // positive move turns the hand backward
                    first_ph_nxt  = (move_r > 0) ? first_ph_r - 2'd1 : first_ph_r + 2'd1;
                    first_drv_nxt = 4'd1 << first_ph_nxt;
                    step_nxt      = step_r + 1'b1;
                  end else begin
                    first_drv_nxt = '0;
                    phase_nxt     = chss_pkg::PH_LOWER;
                    step_nxt      = '0;
                  end
                end
                chss_pkg::PH_LOWER: begin
                  if (step_r < lift_ext) begin
                    second_ph_nxt  = second_ph_r - 2'd1;
                    second_drv_nxt = 4'd1 << second_ph_nxt;
                    step_nxt       = step_r + 1'b1;
                  end else begin
                    first_drv_nxt  = '0;
                    second_drv_nxt = '0;
                    phase_nxt      = chss_pkg::PH_IDLE;
                    step_nxt       = '0;
                    settled_nxt    = pending_r;
                  end
                end
                chss_pkg::PH_ROTATE: begin
                  // step < floor(prod/360) is (step+1)*360 <= prod, kept as a
                  // running sum; the total saturates at the counter maximum
                  if ((step_r != chss_pkg::STEP_MAX) && (rot_acc_r <= rot_prod_r)) begin
                    second_ph_nxt  = rot_fwd_r ? second_ph_r + 2'd1 : second_ph_r - 2'd1;
                    second_drv_nxt = 4'd1 << second_ph_nxt;
                    step_nxt       = step_r + 1'b1;
                    rot_acc_nxt    = rot_acc_r + chss_pkg::DEG_PER_TURN;
                  end else begin
                    second_drv_nxt = '0;
                    phase_nxt      = chss_pkg::PH_IDLE;
                    step_nxt       = '0;
                  end
                end
                default: begin
                  phase_nxt = chss_pkg::PH_IDLE;
                end
              endcase
            end else begin
              tick_nxt = tick_inc[15:0];
            end
          end
        end
        chss_pkg::OP_START: begin
          if (!busy && !((move_new == 9'd0) && (cfg.lift_steps == 12'd0))) begin
            pending_nxt = target_minutes;
            move_nxt    = move_new;
            phase_nxt   = chss_pkg::PH_LIFT;
            step_nxt    = '0;
            tick_nxt    = '0;
            taken       = 1'b1;
          end
        end
        chss_pkg::OP_ROTATE: begin
          if (!busy && (rot_prod >= chss_pkg::DEG_PER_TURN)) begin
            rot_prod_nxt = rot_prod;
            rot_acc_nxt  = chss_pkg::DEG_PER_TURN;
            rot_fwd_nxt  = !deg_bits[15] && (deg_bits != 16'd0);
            phase_nxt    = chss_pkg::PH_ROTATE;
            step_nxt     = '0;
            tick_nxt     = '0;
            taken        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.first_coils    = first_drv_nxt;
    res_nxt.second_coils   = second_drv_nxt;
    res_nxt.busy           = (phase_nxt != chss_pkg::PH_IDLE);
    res_nxt.phase          = phase_nxt;
    res_nxt.taken          = taken;
    res_nxt.settled_target = settled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= chss_pkg::PH_IDLE;
      step_r       <= '0;
      tick_r       <= '0;
      move_r       <= '0;
      pending_r    <= '0;
      settled_r    <= '0;
      rot_prod_r   <= '0;
      rot_acc_r    <= '0;
      rot_fwd_r    <= 1'b0;
      first_ph_r   <= '0;
      second_ph_r  <= '0;
      first_drv_r  <= '0;
      second_drv_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      tick_r       <= tick_nxt;
      move_r       <= move_nxt;
      pending_r    <= pending_nxt;
      settled_r    <= settled_nxt;
      rot_prod_r   <= rot_prod_nxt;
      rot_acc_r    <= rot_acc_nxt;
      rot_fwd_r    <= rot_fwd_nxt;
      first_ph_r   <= first_ph_nxt;
      second_ph_r  <= second_ph_nxt;
      first_drv_r  <= first_drv_nxt;
      second_drv_r <= second_drv_nxt;
    end
  end

  // settled target moves only when a hand sequence finishes its lower phase
  a_settle_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(settled_r) |-> ($past(phase_r) == chss_pkg::PH_LOWER) &&
                            (phase_r == chss_pkg::PH_IDLE))
    else $error("settled target changed outside lower completion");

  // rotate running sum tracks (step+1)*360
  a_rot_acc_track: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == chss_pkg::PH_ROTATE) |->
      (rot_acc_r == chss_pkg::ROT_W'(step_r) * chss_pkg::DEG_PER_TURN + chss_pkg::DEG_PER_TURN))
    else $error("rotate step sum out of step with counter");

endmodule

>>> tb/tb_clock_hand_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// tb_clock_hand_stepper_sequencer
// Self-checking bench for the two-motor clock hand sequencer. A behavioral
// copy of the lift / turn / lower and free-rotate sequences predicts the coil
// drive, phase, taken flag and settled target after every item. Each result
// taken from the block is compared field by field in order. Directed tests
// cover reset defaults, edge settings, registers changed under a running
// sequence and a rotation held at the step ceiling. Random traffic runs in
// between with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_clock_hand_stepper_sequencer;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = chss_pkg::OP_TICK;
  logic signed [7:0]     in_target_minutes = '0;
  logic signed [15:0]    in_rotate_degrees = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [3:0]            out_first_coils;
  logic [3:0]            out_second_coils;
  logic                  out_busy_res;
  logic [2:0]            out_phase_now;
  logic                  out_command_taken;
  logic signed [7:0]     out_settled_target;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = chss_pkg::CFG_STEP_INTERVAL;
  logic [chss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  clock_hand_stepper_sequencer u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies
  logic [15:0] ival;
  logic [11:0] lift;
  logic [7:0]  spm;
  logic [12:0] spt;

  // Sequencer copy
  chss_pkg::chss_phase_t seq_ph;
  int unsigned       step_n;
  int unsigned       tick_n;
  int unsigned       rot_total;
  int                move_min;
  logic signed [7:0] pend_tgt;
  logic signed [7:0] settled;
  bit                rot_fwd;
  logic [1:0]        ph_one;
  logic [1:0]        ph_two;
  logic [3:0]        drv_one;
  logic [3:0]        drv_two;

  chss_pkg::chss_res_t drive_states[$];
  chss_pkg::chss_res_t want;
  bit        gaps_on;
  int        stall_left;
  int        n_err;
  int        n_items;
  int        n_res;
  int        n_taken;
  int        n_hand_done;
  int        n_rot_done;

  task automatic report_mismatch(string what, int got, int exp_v);
    n_err++;
    if (n_err <= 40)
      $display("mismatch at result %0d: %s got %0d, want %0d", n_res, what, got, exp_v);
  endtask

  task automatic reset_motors();
    ival = chss_pkg::RST_STEP_INTERVAL;
    lift = chss_pkg::RST_LIFT_STEPS;
    spm = chss_pkg::RST_STEPS_PER_MIN;
    spt = chss_pkg::RST_STEPS_PER_TURN;
    seq_ph = chss_pkg::PH_IDLE;
    step_n = 0;
    tick_n = 0;
    rot_total = 0;
    move_min = 0;
    pend_tgt = '0;
    settled = '0;
    rot_fwd = 1'b0;
    ph_one = '0;
    ph_two = '0;
    drv_one = '0;
    drv_two = '0;
  endtask

  function automatic int unsigned hand_steps();
    return (move_min < 0 ? -move_min : move_min) * spm;
  endfunction

  task automatic step_second(bit fwd);
    ph_two = ph_two + (fwd ? 2'd1 : 2'd3);
    drv_two = 4'd1 << ph_two;
    step_n++;
  endtask

  // One sequence action, reading the registers as they stand now
  task automatic take_action();
    case (seq_ph)
      chss_pkg::PH_LIFT: begin
        if (step_n < lift) begin
          step_second(1'b1);
        end else begin
          drv_two = '0;
          seq_ph = chss_pkg::PH_TURN;
          step_n = 0;
        end
      end
      chss_pkg::PH_TURN: begin
        if (step_n < hand_steps()) begin
          // positive move turns the hand backward
          ph_one = ph_one + (move_min > 0 ? 2'd3 : 2'd1);
          drv_one = 4'd1 << ph_one;
          step_n++;
        end else begin
          drv_one = '0;
          seq_ph = chss_pkg::PH_LOWER;
          step_n = 0;
        end
      end
      chss_pkg::PH_LOWER: begin
        if (step_n < lift) begin
          step_second(1'b0);
        end else begin
          drv_one = '0;
          drv_two = '0;
          seq_ph = chss_pkg::PH_IDLE;
          step_n = 0;
          settled = pend_tgt;
          n_hand_done++;
        end
      end
      chss_pkg::PH_ROTATE: begin
        if (step_n < rot_total) begin
          step_second(rot_fwd);
        end else begin
          drv_two = '0;
          seq_ph = chss_pkg::PH_IDLE;
          step_n = 0;
          n_rot_done++;
        end
      end
      default: seq_ph = chss_pkg::PH_IDLE;
    endcase
  endtask

  task automatic advance_motors(chss_pkg::chss_op_t op, logic signed [7:0] tgt,
                                logic signed [15:0] deg);
    bit        busy;
    bit        taken;
    int        mv;
    longint    mag;
    longint    total;
    chss_pkg::chss_res_t r;
    busy = (seq_ph != chss_pkg::PH_IDLE);
    taken = 1'b0;
    case (op)
      chss_pkg::OP_TICK: begin
        if (busy) begin
          // interval zero behaves as one
          if (tick_n + 1 >= ival) begin
            tick_n = 0;
            take_action();
          end else begin
            tick_n = tick_n + 1;
          end
        end
      end
      chss_pkg::OP_START: begin
        mv = int'(tgt) - int'(settled);
        if (!busy && !(mv == 0 && lift == 0)) begin
          pend_tgt = tgt;
          move_min = mv;
          seq_ph = chss_pkg::PH_LIFT;
          step_n = 0;
          tick_n = 0;
          taken = 1'b1;
        end
      end
      chss_pkg::OP_ROTATE: begin
        mag = (deg < 0) ? -longint'(deg) : longint'(deg);
        total = mag * longint'(spt) / 360;
        if (total > longint'(chss_pkg::STEP_MAX)) total = longint'(chss_pkg::STEP_MAX);
        if (!busy && total != 0) begin
          rot_total = int'(total);
          rot_fwd = (deg > 0);
          seq_ph = chss_pkg::PH_ROTATE;
          step_n = 0;
          tick_n = 0;
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.first_coils = drv_one;
    r.second_coils = drv_two;
    r.busy = (seq_ph != chss_pkg::PH_IDLE);
    r.phase = seq_ph;
    r.taken = taken;
    r.settled_target = settled;
    drive_states.push_back(r);
    n_items++;
    if (taken) n_taken++;
  endtask

  task automatic send_command(chss_pkg::chss_op_t op, logic signed [7:0] tgt,
                              logic signed [15:0] deg);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_target_minutes <= tgt;
    in_rotate_degrees <= deg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_motors(op, tgt, deg);
  endtask

  task automatic send_tick();
    send_command(chss_pkg::OP_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_to_idle();
    while (seq_ph != chss_pkg::PH_IDLE) send_tick();
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (drive_states.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(chss_pkg::chss_cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      chss_pkg::CFG_STEP_INTERVAL:  ival = val;
      chss_pkg::CFG_LIFT_STEPS:     lift = val[11:0];
      chss_pkg::CFG_STEPS_PER_MIN:  spm = val[7:0];
      chss_pkg::CFG_STEPS_PER_TURN: spt = val[12:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    gaps_on = 1'b1;
    send_tick();
    send_command(chss_pkg::OP_NOP, 8'sh7f, 16'sh7fff);
    send_command(chss_pkg::OP_NOP, 8'sh80, 16'sh8000);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sd0);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sd1);
    // commands while busy are dropped
    send_command(chss_pkg::OP_START, 8'sh7f, 16'sd0);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sh8000);
    run_to_idle();
    send_command(chss_pkg::OP_START, 8'sd0, 16'sd0);
    send_tick();
    send_command(chss_pkg::OP_START, 8'sh80, 16'sd0);
    run_to_idle();
    send_command(chss_pkg::OP_START, 8'sd1, 16'sd0);
    run_to_idle();
  endtask

  task automatic test_edge_settings();
    drain_results();
    write_reg(chss_pkg::CFG_STEP_INTERVAL, 16'd0);
    write_reg(chss_pkg::CFG_LIFT_STEPS, 16'd0);
    write_reg(chss_pkg::CFG_STEPS_PER_MIN, 16'd1);
    write_reg(chss_pkg::CFG_STEPS_PER_TURN, 16'd1);
    // zero move with no lift gives nothing to do
    send_command(chss_pkg::OP_START, settled, 16'sd0);
    send_command(chss_pkg::OP_START, 8'sh80, 16'sd0);
    run_to_idle();
    send_command(chss_pkg::OP_START, 8'sh7f, 16'sd0);
    run_to_idle();
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sh7fff);
    run_to_idle();
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sh8000);
    run_to_idle();
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sd359);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, -16'sd1);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sd360);
    run_to_idle();
    drain_results();
    write_reg(chss_pkg::CFG_STEPS_PER_TURN, 16'd0);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sh7fff);
  endtask

  task automatic test_live_registers();
    drain_results();
    write_reg(chss_pkg::CFG_STEP_INTERVAL, 16'hffff);
    write_reg(chss_pkg::CFG_STEPS_PER_TURN, 16'd360);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sd3);
    repeat (20) send_tick();
    drain_results();
    // count already past the new interval: act on the next tick
    write_reg(chss_pkg::CFG_STEP_INTERVAL, 16'd1);
    run_to_idle();
    drain_results();
    write_reg(chss_pkg::CFG_LIFT_STEPS, 16'hffff);
    write_reg(chss_pkg::CFG_STEPS_PER_MIN, 16'hffff);
    send_command(chss_pkg::OP_START, settled + 8'sd1, 16'sd0);
    repeat (30) send_tick();
    drain_results();
    write_reg(chss_pkg::CFG_LIFT_STEPS, 16'd4);
    run_to_idle();
  endtask

  task automatic test_random_traffic();
    logic signed [7:0]  t;
    logic signed [15:0] d;
    int                 pick;
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = (ph < 4) && (ph != 2);
      drain_results();
      write_reg(chss_pkg::CFG_STEP_INTERVAL, 16'($urandom_range(0, 3)));
      write_reg(chss_pkg::CFG_LIFT_STEPS,
                ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      write_reg(chss_pkg::CFG_STEPS_PER_MIN, 16'($urandom_range(1, 4)));
      write_reg(chss_pkg::CFG_STEPS_PER_TURN, 16'($urandom_range(1, 90)));
      for (int i = 0; i < 285; i++) begin
        if (i == 140) drain_results();
        pick = $urandom_range(0, 99);
        if (seq_ph == chss_pkg::PH_IDLE && $urandom_range(0, 1) == 1)
          pick = $urandom_range(80, 96);
        if (pick < 80) begin
          send_tick();
        end else if (pick < 89) begin
          t = settled + 8'($urandom_range(0, 12));
          t = t - 8'sd6;
          if (seq_ph != chss_pkg::PH_IDLE) t = 8'($urandom);
          send_command(chss_pkg::OP_START, t, 16'($urandom));
        end else if (pick < 97) begin
          d = 16'($urandom_range(0, 200));
          if ($urandom_range(0, 1) == 1) d = -d;
          if (seq_ph != chss_pkg::PH_IDLE) d = 16'($urandom);
          send_command(chss_pkg::OP_ROTATE, 8'($urandom), d);
        end else begin
          send_command(chss_pkg::OP_NOP, 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic test_step_ceiling();
    gaps_on = 1'b0;
    drain_results();
    write_reg(chss_pkg::CFG_STEP_INTERVAL, 16'd0);
    write_reg(chss_pkg::CFG_STEPS_PER_TURN, 16'hffff);
    send_command(chss_pkg::OP_ROTATE, 8'sd0, 16'sh8000);
    run_to_idle();
  endtask

  // Result side: decide at the falling edge what the next rising edge takes
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_res++;
      if (drive_states.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = drive_states.pop_front();
        if (out_first_coils != want.first_coils)
          report_mismatch("first_coils", out_first_coils, want.first_coils);
        if (out_second_coils != want.second_coils)
          report_mismatch("second_coils", out_second_coils, want.second_coils);
        if (out_busy_res != want.busy)
          report_mismatch("busy_res", out_busy_res, want.busy);
        if (out_phase_now != want.phase)
          report_mismatch("phase_now", out_phase_now, want.phase);
        if (out_command_taken != want.taken)
          report_mismatch("command_taken", out_command_taken, want.taken);
        if (out_settled_target != want.settled_target)
          report_mismatch("settled_target", out_settled_target, want.settled_target);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #36_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    reset_motors();
    gaps_on = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_edge_settings();
    test_live_registers();
    test_random_traffic();
    test_step_ceiling();
    drain_results();
    repeat (8) @(posedge clk);
    if (drive_states.size() != 0) report_mismatch("results never returned", 0, 1);
    $display("ran %0d items, %0d results checked, %0d commands taken", n_items, n_res, n_taken);
    $display("finished %0d hand moves and %0d free rotations, one at the step ceiling",
             n_hand_done, n_rot_done);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/chss_pkg.sv
rtl/core/chss_seq_core.sv
rtl/core/clock_hand_stepper_sequencer.sv
tb/tb_clock_hand_stepper_sequencer.sv
